// ===== src/bqe_pkg.sv =====
`default_nettype none

package bqe_pkg;

  // Store geometry.
  localparam int unsigned WORDS   = 32;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = $clog2(WORDS);
  localparam int unsigned OFF_W   = $clog2(WORD_W);
  localparam int unsigned SPAN_W  = IDX_W + 1;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned BIDX_W  = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned PCNT_W  = OFF_W + 1;

  // Stream payload widths.
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CFG_W      = 6;

  // Constants for the bit-parallel popcount and the all-ones test.
  localparam logic [WORD_W-1:0] M1   = 32'h5555_5555;
  localparam logic [WORD_W-1:0] M2   = 32'h3333_3333;
  localparam logic [WORD_W-1:0] M4   = 32'h0F0F_0F0F;
  localparam logic [WORD_W-1:0] ONES = 32'hFFFF_FFFF;

  localparam logic [CFG_W-1:0] WORDS_RESET = CFG_W'(WORDS);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE       = 3'd0,
    OP_COUNT_SET   = 3'd1,
    OP_COUNT_CLEAR = 3'd2,
    OP_FIRST_CLEAR = 3'd3,
    OP_READ_BIT    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_RDBIT = 3'b100
  } state_e;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic             clear;
    logic             valid;
    logic [IDX_W-1:0] idx;
  } scan_ctrl_t;

  // Accumulated scan results.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] pos;
    logic             found;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== src/bitmap_query_engine.sv =====
`default_nettype none

// Channel  | Direction | Handshake            | Contents (lowest bit first)
// s_axis   | in        | tvalid / tready      | tuser: op; tdata: word_index, word_data, bit_index
// m_axis   | out       | tvalid / tready      | tdata: bit_count, free_position, full_res, bit_value
// cfg      | in        | cfg_valid / cfg_ready| cfg_data: words_in_use
//
// Write word and undefined ops answer in the cycle after acceptance.
// Read bit goes through the store read register, then the result register.
// Count and first-clear ops scan the words in use (words_in_use, capped at 32), or
// answer in the cycle after acceptance when words_in_use is 0: the single store
// read port delivers one word per cycle to the scan unit.
// Reset is asynchronous and active low; words_in_use resets to 32, the store is not cleared.
// A new word is taken only when idle and the result register is free or being drained.

module bitmap_query_engine import bqe_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // word_index, word_data, bit_index, zero pad
  input  wire logic [OP_W-1:0]       s_axis_tuser,  // op
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // bit_count, free_position, full_res,
                                                    // bit_value, zero pad
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  // Input field unpacking.
  logic [IDX_W-1:0]  in_word_index;
  logic [WORD_W-1:0] in_word_data;
  logic [BIDX_W-1:0] in_bit_index;
  op_e               in_op;

  assign in_word_index = s_axis_tdata[4:0];
  assign in_word_data  = s_axis_tdata[36:5];
  assign in_bit_index  = s_axis_tdata[46:37];
  assign in_op         = op_e'(s_axis_tuser);

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [CFG_W-1:0]  words_q;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] addr_q, addr_d;
  logic              rd_valid_q, rd_valid_d;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [OFF_W-1:0]  bsel_q, bsel_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic              out_full_q, out_full_d;
  logic              out_bit_q, out_bit_d;
  logic              accept, issue, store_we;
  logic [IDX_W-1:0]  raddr;
  logic [WORD_W-1:0] rdata;
  scan_ctrl_t        ctrl;
  scan_res_t         res;

  // Configuration register, always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= WORDS_RESET;
    end else if (cfg_valid) begin
      words_q <= cfg_data;
    end
  end

  // Words covered by queries, saturated to the store depth.
  assign span = (words_q > CFG_W'(WORDS)) ? SPAN_W'(WORDS) : SPAN_W'(words_q);

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign issue         = (state_q == ST_SCAN) && (addr_q < span);
  assign store_we      = accept && (in_op == OP_WRITE);
  assign raddr         = (state_q == ST_IDLE) ? in_bit_index[BIDX_W-1:OFF_W]
                                              : addr_q[IDX_W-1:0];

  bqe_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (in_word_index),
    .wdata_i (in_word_data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ctrl.clear = accept;
  assign ctrl.valid = rd_valid_q;
  assign ctrl.idx   = rd_idx_q;

  bqe_scan_unit u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .word_i (rdata),
    .res_o  (res)
  );

  // Sequencer and result register.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    bsel_d      = bsel_q;
    rd_valid_d  = issue;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_cnt_d   = out_cnt_q;
    out_pos_d   = out_pos_q;
    out_full_d  = out_full_q;
    out_bit_d   = out_bit_q;
    if (issue) begin
      addr_d = addr_q + SPAN_W'(1);
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d      = in_op;
          addr_d    = '0;
          bsel_d    = in_bit_index[OFF_W-1:0];
          out_cnt_d = '0;
          out_pos_d = '0;
          out_full_d = 1'b0;
          out_bit_d = 1'b0;
          unique case (in_op)
            OP_COUNT_SET, OP_COUNT_CLEAR, OP_FIRST_CLEAR: begin
              if (span == '0) begin
                out_full_d  = (in_op == OP_FIRST_CLEAR);
                out_valid_d = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
            OP_READ_BIT: begin
              state_d = ST_RDBIT;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if ((addr_q == span) && !rd_valid_q) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          unique case (op_q)
            OP_COUNT_SET: begin
              out_cnt_d = res.cnt;
            end
            OP_COUNT_CLEAR: begin
              out_cnt_d = (CNT_W'(span) << OFF_W) - res.cnt;
            end
            default: begin
              out_pos_d  = res.found ? res.pos : '0;
              out_full_d = !res.found;
            end
          endcase
        end
      end
      ST_RDBIT: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        out_bit_d   = rdata[bsel_q];
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
      addr_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_valid_q  <= rd_valid_d;
      addr_q      <= addr_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    bsel_q     <= bsel_d;
    rd_idx_q   <= addr_q[IDX_W-1:0];
    out_cnt_q  <= out_cnt_d;
    out_pos_q  <= out_pos_d;
    out_full_q <= out_full_d;
    out_bit_q  <= out_bit_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_bit_q, out_full_q, out_pos_q, out_cnt_q};

endmodule

`default_nettype wire

// ===== src/bqe_store.sv =====
`default_nettype none

module bqe_store import bqe_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [IDX_W-1:0]  waddr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  input  wire logic [IDX_W-1:0]  raddr_i,
  output logic      [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/bqe_scan_unit.sv =====
`default_nettype none

module bqe_scan_unit import bqe_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire scan_ctrl_t        ctrl_i,
  input  wire logic [WORD_W-1:0] word_i,
  output scan_res_t              res_o
);

  logic [WORD_W-1:0] w1, w2, w3;
  logic [PCNT_W-1:0] pcnt;
  logic [WORD_W-1:0] inv, lsb;
  logic [OFF_W-1:0]  off;
  logic              has_zero;
  scan_res_t         res_d, res_q;

  // Bit-parallel popcount of one word.
  always_comb begin
    w1   = word_i - ((word_i >> 1) & M1);
    w2   = (w1 & M2) + ((w1 >> 2) & M2);
    w3   = (w2 + (w2 >> 4)) & M4;
    pcnt = PCNT_W'(w3[7:0]) + PCNT_W'(w3[15:8]) + PCNT_W'(w3[23:16]) + PCNT_W'(w3[31:24]);
  end

  // Lowest clear bit: isolate the lowest set bit of the inverse and encode it.
  always_comb begin
    inv      = ~word_i;
    lsb      = inv & (~inv + WORD_W'(1));
    has_zero = (word_i != ONES);
    off      = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lsb[i]) begin
        off = off | OFF_W'(i);
      end
    end
  end

  // Accumulate one word per valid cycle.
  always_comb begin
    res_d = res_q;
    if (ctrl_i.clear) begin
      res_d = '0;
    end else if (ctrl_i.valid) begin
      res_d.cnt = res_q.cnt + CNT_W'(pcnt);
      if (!res_q.found && has_zero) begin
        res_d.found = 1'b1;
        res_d.pos   = POS_W'({ctrl_i.idx, off});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== src/bqe_checker.sv =====
`default_nettype none

module bqe_checker import bqe_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic [OP_W-1:0]       s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_W-1:0]      cfg_data
);

  // A stalled result word holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // A write word is answered in the next cycle with an all-zero word.
  a_write_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_WRITE))
      |=> (m_axis_tvalid && (m_axis_tdata == '0)))
    else $error("write word not answered with zeros");

  // A full search reports no position, no count and no bit value.
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[21])
      |-> ((m_axis_tdata[20:11] == '0) && (m_axis_tdata[10:0] == '0) && !m_axis_tdata[22]))
    else $error("full flag mixed with other fields");

  // A count never exceeds the bits of the store.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:0] <= CNT_W'(WORDS * WORD_W)))
    else $error("bit count out of range");

endmodule

bind bitmap_query_engine bqe_checker u_bqe_checker (.*);

`default_nettype wire

// ===== tb/sv/bqe_answer_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, answer and register channels of the bitmap query
// engine, keeps its own copy of the bitmap and of words_in_use, and checks
// every answer word against the oldest outstanding prediction.
module bqe_answer_checker import bqe_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  input  wire logic                  s_tready_i,
  input  wire logic [IN_DATA_W-1:0]  s_tdata_i,
  input  wire logic [OP_W-1:0]       s_tuser_i,
  input  wire logic                  m_tvalid_i,
  input  wire logic                  m_tready_i,
  input  wire logic [OUT_DATA_W-1:0] m_tdata_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  output int                         pending_o,
  output int                         errors_o
);

  // Answer word layout, lowest field in the lowest bits.
  typedef struct packed {
    logic             bit_value;
    logic             full_res;
    logic [POS_W-1:0] free_position;
    logic [CNT_W-1:0] bit_count;
  } answer_t;

  logic [WORD_W-1:0] bitmap_copy [WORDS];
  logic [CFG_W-1:0]  span_setting = WORDS_RESET;
  answer_t           answers_due [$];
  int                pending = 0;
  int                errors = 0;

  assign pending_o = pending;
  assign errors_o  = errors;

  initial begin
    foreach (bitmap_copy[i]) bitmap_copy[i] = '0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t ns: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Applies one request to the bitmap copy and works out its answer word.
  function automatic answer_t predict_answer(input logic [OP_W-1:0] op,
                                             input logic [IDX_W-1:0] widx,
                                             input logic [WORD_W-1:0] wdata,
                                             input logic [BIDX_W-1:0] bidx);
    answer_t     ans;
    int unsigned span;
    int unsigned set_bits;
    bit          hit;
    ans = '0;
    span = (span_setting > WORDS) ? WORDS : span_setting;
    set_bits = 0;
    hit = 1'b0;
    case (op)
      OP_WRITE: begin
        bitmap_copy[widx] = wdata;
      end
      OP_COUNT_SET, OP_COUNT_CLEAR: begin
        for (int i = 0; i < span; i++) set_bits += $countones(bitmap_copy[i]);
        ans.bit_count = (op == OP_COUNT_SET) ? CNT_W'(set_bits)
                                             : CNT_W'(span * WORD_W - set_bits);
      end
      OP_FIRST_CLEAR: begin
        // Lowest clear bit across the words in use; an empty span is full.
        for (int i = 0; i < span; i++) begin
          for (int b = 0; b < WORD_W; b++) begin
            if (!hit && !bitmap_copy[i][b]) begin
              ans.free_position = POS_W'(i * WORD_W + b);
              hit = 1'b1;
            end
          end
        end
        ans.full_res = !hit;
      end
      OP_READ_BIT: begin
        ans.bit_value = bitmap_copy[bidx[BIDX_W-1:OFF_W]][bidx[OFF_W-1:0]];
      end
      default: begin
        // Undefined operations leave the bitmap alone and answer zero.
      end
    endcase
    return ans;
  endfunction

  // Everything is sampled on the falling edge before the rising edge that takes it.
  always @(negedge clk_i) begin : monitor
    answer_t got;
    answer_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) span_setting = cfg_data_i;

      if (m_tvalid_i && m_tready_i) begin
        got = answer_t'(m_tdata_i[$bits(answer_t)-1:0]);
        if (answers_due.size() == 0) begin
          report_mismatch("unrequested answer word", int'(got), -1);
        end else begin
          want = answers_due.pop_front();
          if (got.bit_count != want.bit_count)
            report_mismatch("bit_count", got.bit_count, want.bit_count);
          if (got.free_position != want.free_position)
            report_mismatch("free_position", got.free_position, want.free_position);
          if (got.full_res != want.full_res)
            report_mismatch("full_res", got.full_res, want.full_res);
          if (got.bit_value != want.bit_value)
            report_mismatch("bit_value", got.bit_value, want.bit_value);
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        answers_due.push_back(predict_answer(s_tuser_i, s_tdata_i[4:0],
                                             s_tdata_i[36:5], s_tdata_i[46:37]));
      end
      pending = answers_due.size();
    end
  end

endmodule

// ===== tb/sv/bitmap_query_engine_tb.sv =====
`timescale 1ns / 100ps

// Drives requests and register writes into the bitmap query engine, paces
// the answer side, and gives the verdict from the checker's error and pending counts.
module bitmap_query_engine_tb;
  import bqe_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 115;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;

  int                    outstanding;
  int                    mismatches;
  logic [WORDS-1:0]      written = '0;
  logic [CFG_W-1:0]      cur_span = WORDS_RESET;
  int unsigned           burst_left = 0;
  bit                    sender_gappy = 1'b1;
  int unsigned           rx_mode = 0;
  logic                  long_hold_req = 1'b0;
  int                    idle_cycles = 0;

  bitmap_query_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  bqe_answer_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .pending_o   (outstanding),
    .errors_o    (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Answer side: a long hold on request, otherwise a per-phase stall pattern.
  initial begin : answer_pacer
    bit          rx_stall;
    int unsigned rx_run;
    rx_stall = 1'b0;
    rx_run = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 2) != 0);
          default: begin
            if (rx_run == 0) begin
              rx_stall = !rx_stall;
              rx_run = rx_stall ? $urandom_range(1, 12) : $urandom_range(1, 20);
            end
            rx_run--;
            m_axis_tready <= !rx_stall;
          end
        endcase
      end
    end
  end

  // Ends the run when no word moves on any channel for too long.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offers one request word, in bursts with random gaps between them when sender_gappy is set.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] widx,
                           input logic [WORD_W-1:0] wdata, input logic [BIDX_W-1:0] bidx);
    int unsigned gap;
    logic        took;
    if (burst_left == 0) begin
      gap = sender_gappy ? $urandom_range(0, 10) : 0;
      burst_left = $urandom_range(1, 20);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, bidx, wdata, widx};
    s_axis_tuser  <= op;
    if (op == OP_WRITE) written[widx] = 1'b1;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // Stops offering and waits until every answer is back and the block is idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_span(input logic [CFG_W-1:0] value);
    logic took;
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk_i);
      took = cfg_ready;
      @(posedge clk_i);
    end while (!took);
    cfg_valid <= 1'b0;
    cur_span = value;
  endtask

  // A query may only touch words that have been written at least once.
  function automatic bit reads_ok(input logic [OP_W-1:0] op, input logic [BIDX_W-1:0] bidx);
    int unsigned span;
    span = (cur_span > WORDS) ? WORDS : cur_span;
    case (op)
      OP_COUNT_SET, OP_COUNT_CLEAR, OP_FIRST_CLEAR: begin
        for (int i = 0; i < span; i++) if (!written[i]) return 1'b0;
      end
      OP_READ_BIT: return written[bidx[BIDX_W-1:OFF_W]];
      default: ;
    endcase
    return 1'b1;
  endfunction

  // Store words lean toward all ones so that searches run deep.
  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return ONES;
    if (r == 5) return '0;
    if (r == 6) return ~(32'd1 << $urandom_range(0, WORD_W - 1));
    return $urandom();
  endfunction

  task automatic issue_random();
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  widx;
    logic [BIDX_W-1:0] bidx;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if (r < 35)      op = OP_WRITE;
    else if (r < 50) op = OP_COUNT_SET;
    else if (r < 62) op = OP_COUNT_CLEAR;
    else if (r < 80) op = OP_FIRST_CLEAR;
    else if (r < 95) op = OP_READ_BIT;
    else             op = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    widx = IDX_W'($urandom_range(0, WORDS - 1));
    bidx = BIDX_W'($urandom_range(0, 1023));
    if (!reads_ok(op, bidx)) begin
      op = OP_WRITE;
      for (int i = WORDS - 1; i >= 0; i--) if (!written[i]) widx = IDX_W'(i);
    end
    send_word(op, widx, pick_word(), bidx);
  endtask

  // Rewrites the whole store with one pattern, then queries it.
  task automatic fill_store(input int unsigned mode);
    logic [WORD_W-1:0] w;
    int unsigned       k;
    k = $urandom_range(0, WORDS - 1);
    for (int i = 0; i < WORDS; i++) begin
      case (mode)
        0: w = '0;
        1: w = ONES;
        2: w = (i == WORDS - 1) ? 32'h7FFF_FFFF : ONES;
        default: w = (i < k) ? ONES : pick_word();
      endcase
      send_word(OP_WRITE, IDX_W'(i), w, BIDX_W'($urandom()));
    end
    send_word(OP_COUNT_SET, IDX_W'($urandom()), $urandom(), BIDX_W'($urandom()));
    send_word(OP_COUNT_CLEAR, IDX_W'($urandom()), $urandom(), BIDX_W'($urandom()));
    send_word(OP_FIRST_CLEAR, IDX_W'($urandom()), $urandom(), BIDX_W'($urandom()));
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0]  spans [PHASES];
    int unsigned       fills [PHASES];
    spans = '{6'd32, 6'd63, 6'd2, 6'd33, 6'd0, 6'd32};
    fills = '{0, 1, 2, 3, 3, 2};
    spans[4] = CFG_W'($urandom_range(1, 63));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: an empty span, store edges, undefined operations.
    write_span(6'd0);
    send_word(OP_WRITE, 5'd0, ONES, 10'd0);
    send_word(OP_WRITE, 5'd31, 32'd0, 10'd1023);
    send_word(OP_READ_BIT, 5'd31, 32'd0, 10'd0);
    send_word(OP_READ_BIT, 5'd0, ONES, 10'd1023);
    send_word(OP_READ_BIT, IDX_W'($urandom()), $urandom(), 10'd31);
    send_word(OP_COUNT_SET, IDX_W'($urandom()), $urandom(), BIDX_W'($urandom()));
    send_word(OP_COUNT_CLEAR, IDX_W'($urandom()), $urandom(), BIDX_W'($urandom()));
    send_word(OP_FIRST_CLEAR, IDX_W'($urandom()), $urandom(), BIDX_W'($urandom()));
    for (int op = OP_UNDEF_LO; op <= OP_UNDEF_HI; op++) begin
      send_word(OP_W'(op), 5'd31, ONES, 10'd1023);
    end

    // Directed: a one-word span, full word, top and bottom clear bits.
    write_span(6'd1);
    send_word(OP_COUNT_SET, 5'd0, 32'd0, 10'd0);
    send_word(OP_COUNT_CLEAR, 5'd0, 32'd0, 10'd0);
    send_word(OP_FIRST_CLEAR, 5'd0, 32'd0, 10'd0);
    send_word(OP_WRITE, 5'd0, 32'h7FFF_FFFF, 10'd0);
    send_word(OP_FIRST_CLEAR, 5'd0, 32'd0, 10'd0);
    send_word(OP_WRITE, 5'd0, 32'hFFFF_FFFE, 10'd0);
    send_word(OP_FIRST_CLEAR, 5'd0, 32'd0, 10'd0);
    send_word(OP_COUNT_SET, 5'd0, 32'd0, 10'd0);
    send_word(OP_WRITE, 5'd0, 32'd0, 10'd0);
    send_word(OP_COUNT_CLEAR, 5'd0, 32'd0, 10'd0);

    // Random phases, each under its own span, answer pacing and fill.
    for (int p = 0; p < PHASES; p++) begin
      write_span(spans[p]);
      rx_mode = p % 3;
      sender_gappy = (p != 3);
      fill_store(fills[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 40) long_hold_req = 1'b1;
        if (p == 2 && n == 60) drain();
        issue_random();
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bqe_pkg.sv
src/bqe_store.sv
src/bqe_scan_unit.sv
src/bitmap_query_engine.sv
src/bqe_checker.sv
tb/sv/bqe_answer_checker.sv
tb/sv/bitmap_query_engine_tb.sv
